@@ src/cdd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdd_pkg: shared types and constants for the calendar date difference block
// Holds the transfer payload structs, per-date result struct and the month
// tables of the Gregorian calendar.
// ----------------------------------------------------------------------------
package cdd_pkg;

    localparam int YEAR_W   = 15;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int DAYS_W   = 25;
    localparam int MONTHS_W = 20;
    localparam int YEARS_W  = 16;
    localparam int SERIAL_W = 24;

    localparam logic [YEAR_W-1:0]  YEAR_MIN        = 15'd1601;
    localparam logic [YEAR_W-1:0]  YEAR_MAX        = 15'd30827;
    localparam logic [MONTH_W-1:0] MONTH_JAN       = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC       = 4'd12;
    localparam logic [4:0]         MONTHS_PER_YEAR = 5'd12;

    typedef struct packed {
        logic [YEAR_W-1:0]  first_year;
        logic [MONTH_W-1:0] first_month;
        logic [DAY_W-1:0]   first_day;
        logic [YEAR_W-1:0]  second_year;
        logic [MONTH_W-1:0] second_month;
        logic [DAY_W-1:0]   second_day;
    } cdd_in_t;

    typedef struct packed {
        logic signed [DAYS_W-1:0]   days_apart;
        logic signed [MONTHS_W-1:0] months_apart;
        logic signed [YEARS_W-1:0]  years_apart;
        logic                       date_invalid;
    } cdd_out_t;

    // Per-date result: day number from 0001-01-01 (day 1) and validity.
    typedef struct packed {
        logic                ok;
        logic [SERIAL_W-1:0] serial;
    } date_info_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
        logic [8:0] start;
        case (m)
            4'd1:    start = 9'd0;
            4'd2:    start = 9'd31;
            4'd3:    start = 9'd59;
            4'd4:    start = 9'd90;
            4'd5:    start = 9'd120;
            4'd6:    start = 9'd151;
            4'd7:    start = 9'd181;
            4'd8:    start = 9'd212;
            4'd9:    start = 9'd243;
            4'd10:   start = 9'd273;
            4'd11:   start = 9'd304;
            4'd12:   start = 9'd334;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

@@ src/cdd_date_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdd_date_eval: day number and validity of one Gregorian date
// Closed-form day count; divisions by 100 use a reciprocal multiply.
// ----------------------------------------------------------------------------
module cdd_date_eval (
    input  logic [cdd_pkg::YEAR_W-1:0]  year,
    input  logic [cdd_pkg::MONTH_W-1:0] month,
    input  logic [cdd_pkg::DAY_W-1:0]   day,
    output cdd_pkg::date_info_t         info
);

    // floor(x / 100) = (x * 5243) >> 19 holds for every 15-bit x
    localparam logic [27:0] RECIP_100 = 28'd5243;
    localparam int          RECIP_SH  = 19;

    logic [14:0] p;
    logic [27:0] p_mul;
    logic [27:0] y_mul;
    logic [8:0]  p_q100;
    logic [8:0]  y_q100;
    logic [14:0] y_rem100;
    logic        leap;
    logic [4:0]  len;
    logic [23:0] serial;

    always_comb begin
        p        = year - 15'd1;
        p_mul    = {13'b0, p} * RECIP_100;
        y_mul    = {13'b0, year} * RECIP_100;
        p_q100   = p_mul[RECIP_SH +: 9];
        y_q100   = y_mul[RECIP_SH +: 9];
        y_rem100 = year - ({6'b0, y_q100} * 15'd100);
        leap     = (year[1:0] == 2'b00) && ((y_rem100 != 15'd0) || (y_q100[1:0] == 2'b00));

        len = cdd_pkg::month_len(month)
            + {4'b0, (month == cdd_pkg::MONTH_FEB) && leap};

        // p/400 is (p/100)/4
        serial = ({9'b0, p} * 24'd365)
               + {11'b0, p[14:2]}
               - {15'b0, p_q100}
               + {17'b0, p_q100[8:2]}
               + {15'b0, cdd_pkg::month_start(month)}
               + {23'b0, (month > cdd_pkg::MONTH_FEB) && leap}
               + {19'b0, day};

        info.serial = serial;
        info.ok     = (year >= cdd_pkg::YEAR_MIN) && (year <= cdd_pkg::YEAR_MAX)
                   && (month >= cdd_pkg::MONTH_JAN) && (month <= cdd_pkg::MONTH_DEC)
                   && (day != 5'd0) && (day <= len);
    end

endmodule

@@ src/calendar_date_difference.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_difference: days, months and years between two dates
// Two-register pipeline that compares a pair of Gregorian dates per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one date pair per transfer; m_valid/m_ready/
//   m_data return one result per pair, in order.
//   A pair lands in the input register, passes through the combinational logic
//   (two day-number units, the year and month rules) and lands in the result
//   register, which drives m_data until the result transfers out.
//   Throughput is one pair per cycle while m_ready stays high; the single logic
//   pass between the two registers sets that figure.
//   When the receiver holds m_ready low the result register holds, the input
//   register fills behind it, and s_ready then drops until the result leaves.
//   If either date is outside 1601..30827, has a month outside 1..12 or a day
//   of zero or beyond its month, date_invalid is set and the counts are zero.
//   Reset (aresetn low, synchronous) drops both valid flags; payload registers
//   keep whatever they held.
// ----------------------------------------------------------------------------
module calendar_date_difference (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cdd_pkg::cdd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cdd_pkg::cdd_out_t m_data
);

    cdd_pkg::cdd_in_t   in_reg;
    logic               in_vld_reg;
    cdd_pkg::cdd_out_t  out_reg;
    cdd_pkg::cdd_out_t  out_next;
    logic               out_vld_reg;
    logic               out_take;

    cdd_pkg::date_info_t first_info;
    cdd_pkg::date_info_t second_info;

    logic signed [15:0] dy;
    logic signed [4:0]  dm;
    logic signed [5:0]  dd;
    logic signed [15:0] years;
    logic signed [4:0]  m_adj;
    logic signed [19:0] years_x;
    logic signed [19:0] months;
    logic signed [24:0] days;

    // Result register can take a new value when empty or being drained.
    assign out_take = !out_vld_reg || m_ready;
    assign s_ready  = !in_vld_reg || out_take;
    assign m_valid  = out_vld_reg;
    assign m_data   = out_reg;

    cdd_date_eval u_first (
        .year  (in_reg.first_year),
        .month (in_reg.first_month),
        .day   (in_reg.first_day),
        .info  (first_info)
    );

    cdd_date_eval u_second (
        .year  (in_reg.second_year),
        .month (in_reg.second_month),
        .day   (in_reg.second_day),
        .info  (second_info)
    );

    always_comb begin
        dy = $signed({1'b0, in_reg.second_year}) - $signed({1'b0, in_reg.first_year});
        dm = $signed({1'b0, in_reg.second_month}) - $signed({1'b0, in_reg.first_month});
        dd = $signed({1'b0, in_reg.second_day}) - $signed({1'b0, in_reg.first_day});

        // Year rule: pull a partial year back toward zero.
        years = dy;
        if (dy < 0) begin
            if ((dm > 0) || (dd > 0)) begin
                years = dy + 16'sd1;
            end
        end else if (dy > 0) begin
            if ((dm < 0) || (dd < 0)) begin
                years = dy - 16'sd1;
            end
        end

        // Month rule: fold the month difference by a year when years differ,
        // then trim a partial month (asymmetric on the day difference).
        m_adj = dm;
        if (dy != 16'sd0) begin
            if (dm < 0) begin
                m_adj = dm + $signed(cdd_pkg::MONTHS_PER_YEAR);
            end else if (dm > 0) begin
                m_adj = dm - $signed(cdd_pkg::MONTHS_PER_YEAR);
            end
        end
        if (m_adj < 0) begin
            if (dd > 0) begin
                m_adj = m_adj + 5'sd1;
            end
        end else if (m_adj > 0) begin
            if (dd != 6'sd0) begin
                m_adj = m_adj - 5'sd1;
            end
        end

        // years equals dy whenever dy is zero, so one product covers both cases
        years_x = {{4{years[15]}}, years};
        months  = (years_x <<< 3) + (years_x <<< 2) + {{15{m_adj[4]}}, m_adj};

        days = $signed({1'b0, second_info.serial}) - $signed({1'b0, first_info.serial});

        if (first_info.ok && second_info.ok) begin
            out_next.days_apart   = days;
            out_next.months_apart = months;
            out_next.years_apart  = years;
            out_next.date_invalid = 1'b0;
        end else begin
            out_next.days_apart   = '0;
            out_next.months_apart = '0;
            out_next.years_apart  = '0;
            out_next.date_invalid = 1'b1;
        end
    end

    // Control: advance valid flags through the two registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (out_take) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // Payload: capture on transfer, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (out_take && in_vld_reg) begin
            out_reg <= out_next;
        end
    end

endmodule
